FILE: rtl/cpcb_pkg.sv
package cpcb_pkg;

	localparam logic [1:0] OP_CC = 2'd0;
	localparam logic [1:0] OP_CB = 2'd1;
	localparam logic [1:0] OP_BC = 2'd2;
	localparam logic [1:0] OP_BB = 2'd3;

	localparam logic [31:0] SIGN_BIT = 32'h8000_0000;
	localparam int HALF_SHIFT = 30;

	localparam int SQ_STEPS = 32;
	localparam int DIV_STEPS = 31;
	localparam int BACK_LAST = 3 + SQ_STEPS + DIV_STEPS;
	localparam int FIFO_DEPTH = 4;

	typedef struct packed {
		logic [1:0] op;
		logic signed [31:0] first_x;
		logic signed [31:0] first_y;
		logic signed [31:0] second_x;
		logic signed [31:0] second_y;
		logic [30:0] circle_radius;
		logic [30:0] half_width;
		logic [30:0] half_height;
	} in_item_t;

	typedef struct packed {
		logic signed [31:0] point_x;
		logic signed [31:0] point_y;
		logic degenerate;
	} out_item_t;

	// classified request handed from front to back
	typedef struct packed {
		logic proj;
		logic signed [33:0] vx;
		logic signed [33:0] vy;
		logic signed [31:0] cx;
		logic signed [31:0] cy;
		logic [30:0] r;
	} work_t;

	typedef struct packed {
		logic proj;
		logic zero;
		logic negx;
		logic negy;
		logic signed [31:0] cx;
		logic signed [31:0] cy;
		logic [30:0] r;
		logic [HALF_SHIFT:0] ax;
		logic [HALF_SHIFT:0] ay;
	} side_t;

	function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
		logic signed [33:0] hi;
		logic signed [33:0] lo;
		hi = $signed({2'b00, ~SIGN_BIT});
		lo = $signed({2'b11, SIGN_BIT});
		if (v > hi) begin
			return $signed(~SIGN_BIT);
		end else if (v < lo) begin
			return $signed(SIGN_BIT);
		end
		return v[31:0];
	endfunction

endpackage

FILE: rtl/cpcb_front.sv
module cpcb_front (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  cpcb_pkg::in_item_t in_data,
	output logic push,
	output cpcb_pkg::work_t push_data,
	input  logic full
);
	import cpcb_pkg::*;

	logic adv;
	logic valid_s1, valid_s2;
	logic [1:0] op_s1;
	logic signed [32:0] dx_s1, dy_s1;
	logic [32:0] adx_s1, ady_s1;
	logic signed [31:0] bx_s1, by_s1, cx_s1, cy_s1, sx_s1, sy_s1;
	logic [30:0] hw_s1, hh_s1, r_s1;
	work_t work_s2, work_c;

	logic signed [31:0] bx_c, by_c, cx_c, cy_c;
	logic signed [32:0] dx_c, dy_c;

	assign adv = !valid_s2 || !full;
	assign in_stall = !adv;
	assign push = valid_s2 && !full;
	assign push_data = work_s2;

	always_comb begin
		// circle-box takes the box from the second centre, box-circle from the first
		if (in_data.op == OP_BC) begin
			bx_c = in_data.first_x;
			by_c = in_data.first_y;
			cx_c = in_data.second_x;
			cy_c = in_data.second_y;
		end else begin
			bx_c = in_data.second_x;
			by_c = in_data.second_y;
			cx_c = in_data.first_x;
			cy_c = in_data.first_y;
		end
		dx_c = $signed({cx_c[31], cx_c}) - $signed({bx_c[31], bx_c});
		dy_c = $signed({cy_c[31], cy_c}) - $signed({by_c[31], by_c});
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			op_s1 <= in_data.op;
			dx_s1 <= dx_c;
			dy_s1 <= dy_c;
			adx_s1 <= dx_c[32] ? 33'(-dx_c) : 33'(dx_c);
			ady_s1 <= dy_c[32] ? 33'(-dy_c) : 33'(dy_c);
			bx_s1 <= bx_c;
			by_s1 <= by_c;
			cx_s1 <= cx_c;
			cy_s1 <= cy_c;
			sx_s1 <= in_data.second_x;
			sy_s1 <= in_data.second_y;
			hw_s1 <= in_data.half_width;
			hh_s1 <= in_data.half_height;
			r_s1 <= in_data.circle_radius;
		end
	end

	always_comb begin
		logic outx, outy;
		logic signed [33:0] exx, exy, qx, qy;
		outx = adx_s1 > {2'b00, hw_s1};
		outy = ady_s1 > {2'b00, hh_s1};
		exx = $signed({1'b0, adx_s1}) - $signed({3'b000, hw_s1});
		exy = $signed({1'b0, ady_s1}) - $signed({3'b000, hh_s1});
		qx = !outx ? 34'($signed(cx_s1)) : dx_s1[32] ?
			34'($signed(bx_s1)) - $signed({3'b000, hw_s1}) :
			34'($signed(bx_s1)) + $signed({3'b000, hw_s1});
		qy = !outy ? 34'($signed(cy_s1)) : dy_s1[32] ?
			34'($signed(by_s1)) - $signed({3'b000, hh_s1}) :
			34'($signed(by_s1)) + $signed({3'b000, hh_s1});
		work_c.proj = (op_s1 == OP_CC) || (op_s1 == OP_BC);
		work_c.r = r_s1;
		work_c.vx = '0;
		work_c.vy = '0;
		work_c.cx = '0;
		work_c.cy = '0;
		case (op_s1)
			OP_CC: begin
				work_c.vx = 34'(dx_s1);
				work_c.vy = 34'(dy_s1);
				work_c.cx = sx_s1;
				work_c.cy = sy_s1;
			end
			OP_BC: begin
				// clamped point minus circle centre, i.e. the excess past the edge
				work_c.vx = !outx ? '0 : dx_s1[32] ? exx : -exx;
				work_c.vy = !outy ? '0 : dy_s1[32] ? exy : -exy;
				work_c.cx = sx_s1;
				work_c.cy = sy_s1;
			end
			OP_CB: begin
				work_c.cx = sat32(qx);
				work_c.cy = sat32(qy);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			work_s2 <= work_c;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
		end
	end

endmodule

FILE: rtl/cpcb_fifo.sv
module cpcb_fifo (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cpcb_pkg::work_t wdata,
	input  logic pop,
	output cpcb_pkg::work_t rdata,
	output logic full,
	output logic empty
);
	import cpcb_pkg::*;

	localparam int AW = $clog2(FIFO_DEPTH);

	work_t mem [FIFO_DEPTH];
	logic [AW-1:0] wr_q, rd_q;
	logic [AW:0] cnt_q;

	assign full = cnt_q == (AW+1)'(FIFO_DEPTH);
	assign empty = cnt_q == '0;
	assign rdata = mem[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

FILE: rtl/cpcb_div.sv
module cpcb_div (
	input  logic clk,
	input  logic en,
	input  logic [61:0] num,
	input  logic [31:0] den,
	output logic [30:0] quo
);
	import cpcb_pkg::*;

	logic [61:0] rem_q [DIV_STEPS];
	logic [31:0] den_q [DIV_STEPS];
	logic [30:0] quo_q [DIV_STEPS];

	for (genvar j = 0; j < DIV_STEPS; j++) begin : g_step
		logic [61:0] rem_in;
		logic [31:0] den_in;
		logic [30:0] quo_in;
		logic [62:0] trial;
		logic ge;
		if (j == 0) begin : g_first
			assign rem_in = num;
			assign den_in = den;
			assign quo_in = '0;
		end else begin : g_next
			assign rem_in = rem_q[j-1];
			assign den_in = den_q[j-1];
			assign quo_in = quo_q[j-1];
		end
		assign trial = {31'd0, den_in} << (DIV_STEPS - 1 - j);
		assign ge = {1'b0, rem_in} >= trial;
		always_ff @(posedge clk) begin
			if (en) begin
				rem_q[j] <= ge ? rem_in - trial[61:0] : rem_in;
				den_q[j] <= den_in;
				quo_q[j] <= {quo_in[29:0], ge};
			end
		end
	end

	assign quo = quo_q[DIV_STEPS-1];

endmodule

FILE: rtl/cpcb_back.sv
module cpcb_back (
	input  logic clk,
	input  logic arst_n,
	input  logic empty,
	input  cpcb_pkg::work_t head,
	output logic pop,
	output logic out_valid,
	input  logic out_stall,
	output cpcb_pkg::out_item_t out_data
);
	import cpcb_pkg::*;

	localparam int AXW = HALF_SHIFT + 1;

	logic adv;
	logic valid_q [BACK_LAST+1];
	side_t side_q [BACK_LAST+1];
	side_t side_c;
	logic [2*AXW-1:0] sqx_q, sqy_q;
	logic [63:0] sum_q;
	logic [35:0] rem_q [SQ_STEPS];
	logic [31:0] root_q [SQ_STEPS];
	logic [63:0] rad_q [SQ_STEPS];
	logic [61:0] prodx_q, prody_q;
	logic [31:0] len_q;
	logic [30:0] quox, quoy;
	logic out_valid_q;
	out_item_t out_q;

	assign adv = !out_valid_q || !out_stall;
	assign pop = adv && !empty;
	assign out_valid = out_valid_q;
	assign out_data = out_q;

	// magnitudes, then scale both down together until they fit AXW bits
	always_comb begin
		logic [33:0] ax, ay, m, shx, shy;
		logic [1:0] k;
		ax = head.vx[33] ? 34'(-head.vx) : 34'(head.vx);
		ay = head.vy[33] ? 34'(-head.vy) : 34'(head.vy);
		m = ax | ay;
		k = m[33] ? 2'd3 : m[32] ? 2'd2 : m[31] ? 2'd1 : 2'd0;
		shx = ax >> k;
		shy = ay >> k;
		side_c.proj = head.proj;
		side_c.zero = m == '0;
		side_c.negx = head.vx[33];
		side_c.negy = head.vy[33];
		side_c.cx = head.cx;
		side_c.cy = head.cy;
		side_c.r = head.r;
		side_c.ax = shx[AXW-1:0];
		side_c.ay = shy[AXW-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k <= BACK_LAST; k++) begin
				valid_q[k] <= 1'b0;
			end
			out_valid_q <= 1'b0;
		end else if (adv) begin
			valid_q[0] <= !empty;
			for (int k = 1; k <= BACK_LAST; k++) begin
				valid_q[k] <= valid_q[k-1];
			end
			out_valid_q <= valid_q[BACK_LAST];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			side_q[0] <= side_c;
			for (int k = 1; k <= BACK_LAST; k++) begin
				side_q[k] <= side_q[k-1];
			end
			sqx_q <= side_q[0].ax * side_q[0].ax;
			sqy_q <= side_q[0].ay * side_q[0].ay;
			sum_q <= 64'(sqx_q) + 64'(sqy_q);
		end
	end

	// digit-by-digit square root, one result bit per stage
	for (genvar j = 0; j < SQ_STEPS; j++) begin : g_sqrt
		logic [35:0] rem_in, rem_sh, t;
		logic [31:0] root_in;
		logic [1:0] pair;
		logic ge;
		if (j == 0) begin : g_first
			assign rem_in = '0;
			assign root_in = '0;
			assign pair = sum_q[63:62];
		end else begin : g_next
			assign rem_in = rem_q[j-1];
			assign root_in = root_q[j-1];
			assign pair = rad_q[j-1][2*(SQ_STEPS-1-j) +: 2];
		end
		assign rem_sh = {rem_in[33:0], pair};
		assign t = {2'b00, root_in, 2'b01};
		assign ge = rem_sh >= t;
		always_ff @(posedge clk) begin
			if (adv) begin
				rem_q[j] <= ge ? rem_sh - t : rem_sh;
				root_q[j] <= {root_in[30:0], ge};
			end
		end
	end

	// radicand stays put in sum_q only for the first step, so carry it along
	always_ff @(posedge clk) begin
		if (adv) begin
			rad_q[0] <= sum_q;
			for (int k = 1; k < SQ_STEPS; k++) begin
				rad_q[k] <= rad_q[k-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			prodx_q <= side_q[3+SQ_STEPS-1].r * side_q[3+SQ_STEPS-1].ax;
			prody_q <= side_q[3+SQ_STEPS-1].r * side_q[3+SQ_STEPS-1].ay;
			len_q <= (root_q[SQ_STEPS-1] == '0) ? 32'd1 : root_q[SQ_STEPS-1];
		end
	end

	cpcb_div u_divx (
		.clk(clk),
		.en(adv),
		.num(prodx_q),
		.den(len_q),
		.quo(quox)
	);

	cpcb_div u_divy (
		.clk(clk),
		.en(adv),
		.num(prody_q),
		.den(len_q),
		.quo(quoy)
	);

	always_ff @(posedge clk) begin
		side_t s;
		logic signed [33:0] px, py;
		s = side_q[BACK_LAST];
		px = s.negx ? 34'(s.cx) - $signed({3'b000, quox}) :
			34'(s.cx) + $signed({3'b000, quox});
		py = s.negy ? 34'(s.cy) - $signed({3'b000, quoy}) :
			34'(s.cy) + $signed({3'b000, quoy});
		if (adv) begin
			if (s.proj && !s.zero) begin
				out_q.point_x <= sat32(px);
				out_q.point_y <= sat32(py);
			end else begin
				out_q.point_x <= s.cx;
				out_q.point_y <= s.cy;
			end
			out_q.degenerate <= s.proj && s.zero;
		end
	end

endmodule

FILE: rtl/contact_point_circle_box.sv
// Contact point for a circle-circle, circle-box or box-circle pair.
// Input channel in_valid/in_stall/in_data carries one request per pair;
// output channel out_valid/out_stall/out_data returns one contact point
// per request, in order. A request is taken when valid is high and stall low.
// Throughput: one request per cycle while the receiver does not stall. The
// normalize path is fully pipelined: a 32-stage square root and two 31-stage
// dividers set the depth.
// A two-stage front classifies the request and clamps against the box, then
// hands it through a four-entry queue to the back pipeline. When the receiver
// stalls, the back pipeline holds, the queue fills, and in_stall rises once
// the front cannot drain. The output register holds a stalled result.
// Reset (arst_n low) empties the pipelines and the queue; nothing is pending
// afterwards and no result is produced without a request.
module contact_point_circle_box (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  cpcb_pkg::in_item_t in_data,
	output logic out_valid,
	input  logic out_stall,
	output cpcb_pkg::out_item_t out_data
);
	import cpcb_pkg::*;

	logic push, pop, full, empty;
	work_t push_data, head;

	cpcb_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_data(in_data),
		.push(push),
		.push_data(push_data),
		.full(full)
	);

	cpcb_fifo u_fifo (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.wdata(push_data),
		.pop(pop),
		.rdata(head),
		.full(full),
		.empty(empty)
	);

	cpcb_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.empty(empty),
		.head(head),
		.pop(pop),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data(out_data)
	);

endmodule

FILE: bench/contact_point_circle_box_tb.sv
`timescale 1ns / 1ps
module contact_point_circle_box_tb;
	import cpcb_pkg::*;

	localparam int N_RANDOM = 1450;
	localparam int CYCLE_LIMIT = 400000;
	localparam int TAIL_CYCLES = 100;

	typedef struct packed {
		logic known;
		out_item_t res;
	} table_res_t;

	typedef struct packed {
		in_item_t req;
		table_res_t want;
	} table_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	in_item_t in_data = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	out_item_t out_data;

	out_item_t point_queue[$];
	int n_mismatch = 0;
	int n_results = 0;
	int n_degen = 0;
	int cycles = 0;
	bit quiet_phase = 1'b0;
	bit send_done = 1'b0;
	table_row_t directed[$];

	contact_point_circle_box i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data(out_data)
	);

	always #1 clk = ~clk;

	function automatic longint clip32(longint v);
		if (v > 64'sd2147483647) return 64'sd2147483647;
		if (v < -64'sd2147483648) return -64'sd2147483648;
		return v;
	endfunction

	function automatic longint unsigned int_sqrt(longint unsigned s);
		longint unsigned res, bitv;
		res = 0;
		bitv = 64'd1 << 62;
		while (bitv > s) bitv >>= 2;
		while (bitv != 0) begin
			if (s >= res + bitv) begin
				s -= res + bitv;
				res = (res >> 1) + bitv;
			end else begin
				res >>= 1;
			end
			bitv >>= 2;
		end
		return res;
	endfunction

	function automatic longint slab_clamp(longint boxc, longint circc, longint unsigned half);
		longint d;
		longint unsigned ad;
		d = circc - boxc;
		ad = (d < 0) ? longint'(-d) : longint'(d);
		if (ad > half) return (d < 0) ? boxc - longint'(half) : boxc + longint'(half);
		return circc;
	endfunction

	function automatic out_item_t onto_circle(longint vx, longint vy, longint unsigned r,
			longint cx, longint cy);
		out_item_t o;
		longint unsigned ax, ay, len, sx, sy;
		ax = (vx < 0) ? longint'(-vx) : longint'(vx);
		ay = (vy < 0) ? longint'(-vy) : longint'(vy);
		if ((ax | ay) == 0) begin
			o.point_x = 32'(clip32(cx));
			o.point_y = 32'(clip32(cy));
			o.degenerate = 1'b1;
			return o;
		end
		while (((ax | ay) >> 31) != 0) begin
			ax >>= 1;
			ay >>= 1;
		end
		len = int_sqrt(ax * ax + ay * ay);
		if (len == 0) len = 1;
		sx = (r * ax) / len;
		sy = (r * ay) / len;
		o.point_x = 32'(clip32(vx < 0 ? cx - longint'(sx) : cx + longint'(sx)));
		o.point_y = 32'(clip32(vy < 0 ? cy - longint'(sy) : cy + longint'(sy)));
		o.degenerate = 1'b0;
		return o;
	endfunction

	function automatic out_item_t contact_point(in_item_t q);
		out_item_t o;
		longint fx, fy, sx, sy, qx, qy;
		longint unsigned r, hw, hh;
		fx = q.first_x;
		fy = q.first_y;
		sx = q.second_x;
		sy = q.second_y;
		r = q.circle_radius;
		hw = q.half_width;
		hh = q.half_height;
		o = '0;
		case (q.op)
			OP_CC: o = onto_circle(fx - sx, fy - sy, r, sx, sy);
			OP_CB: begin
				o.point_x = 32'(clip32(slab_clamp(sx, fx, hw)));
				o.point_y = 32'(clip32(slab_clamp(sy, fy, hh)));
			end
			OP_BC: begin
				qx = slab_clamp(fx, sx, hw);
				qy = slab_clamp(fy, sy, hh);
				o = onto_circle(qx - sx, qy - sy, r, sx, sy);
			end
			default: o = '0;
		endcase
		return o;
	endfunction

	function automatic logic [31:0] rand_coord();
		case ($urandom_range(0, 5))
			0: return 32'h8000_0000 + $urandom_range(0, 3);
			1: return 32'h7FFF_FFFF - $urandom_range(0, 3);
			2: return 32'($signed($urandom_range(0, 2000000)) - 1000000);
			3: return 32'($signed($urandom_range(0, 80)) - 40) << 16;
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [30:0] rand_extent();
		case ($urandom_range(0, 4))
			0: return 31'h7FFF_FFFF - $urandom_range(0, 3);
			1: return 31'($urandom_range(0, 3));
			2: return 31'($urandom_range(0, 20)) << 16;
			default: return 31'($urandom);
		endcase
	endfunction

	function automatic in_item_t rand_request();
		in_item_t q;
		q.op = ($urandom_range(0, 19) == 0) ? OP_BB : 2'($urandom_range(0, 2));
		q.first_x = rand_coord();
		q.first_y = rand_coord();
		// coincident centres now and then to hit the zero-length vector
		if ($urandom_range(0, 9) == 0) begin
			q.second_x = q.first_x;
			q.second_y = q.first_y;
		end else begin
			q.second_x = ($urandom_range(0, 2) == 0) ? rand_coord()
				: q.first_x + 32'($signed($urandom_range(0, 400000)) - 200000);
			q.second_y = ($urandom_range(0, 2) == 0) ? rand_coord()
				: q.first_y + 32'($signed($urandom_range(0, 400000)) - 200000);
		end
		q.circle_radius = rand_extent();
		q.half_width = rand_extent();
		q.half_height = rand_extent();
		return q;
	endfunction

	function automatic in_item_t mk(logic [1:0] op, logic [31:0] fx, logic [31:0] fy,
			logic [31:0] sx, logic [31:0] sy, logic [30:0] r, logic [30:0] hw,
			logic [30:0] hh);
		in_item_t q;
		q.op = op;
		q.first_x = fx;
		q.first_y = fy;
		q.second_x = sx;
		q.second_y = sy;
		q.circle_radius = r;
		q.half_width = hw;
		q.half_height = hh;
		return q;
	endfunction

	function automatic table_res_t typed(logic [31:0] px, logic [31:0] py, logic dg);
		table_res_t t;
		t.known = 1'b1;
		t.res.point_x = px;
		t.res.point_y = py;
		t.res.degenerate = dg;
		return t;
	endfunction

	task automatic build_table();
		table_res_t pred;
		pred = '0;
		directed.push_back('{mk(OP_BB, 32'h7FFF_FFFF, 32'h8000_0000, 32'h1234_5678,
			32'hFFFF_0000, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF), typed(0, 0, 0)});
		directed.push_back('{mk(OP_CC, 32'h0001_0000, 32'h0002_0000, 32'h0001_0000,
			32'h0002_0000, 31'h0001_0000, 0, 0), typed(32'h0001_0000, 32'h0002_0000, 1)});
		directed.push_back('{mk(OP_CC, 32'h000A_0000, 0, 0, 0, 31'h0003_0000, 0, 0),
			typed(32'h0003_0000, 0, 0)});
		directed.push_back('{mk(OP_CC, 0, 32'hFFF6_0000, 0, 0, 31'h0002_0000, 0, 0),
			typed(0, 32'hFFFE_0000, 0)});
		directed.push_back('{mk(OP_CB, 32'h0005_0000, 32'h0000_8000, 0, 0, 0,
			31'h0001_0000, 31'h0001_0000), typed(32'h0001_0000, 32'h0000_8000, 0)});
		directed.push_back('{mk(OP_CB, 32'hFFFB_0000, 32'hFFFB_0000, 0, 0, 0,
			31'h0002_0000, 31'h0003_0000), typed(32'hFFFE_0000, 32'hFFFD_0000, 0)});
		directed.push_back('{mk(OP_BC, 0, 0, 32'h0004_0000, 0, 31'h0001_0000,
			31'h0002_0000, 31'h0002_0000), typed(32'h0003_0000, 0, 0)});
		directed.push_back('{mk(OP_BC, 0, 0, 32'h0001_0000, 32'h0001_0000, 31'h0001_0000,
			31'h0002_0000, 31'h0002_0000), typed(32'h0001_0000, 32'h0001_0000, 1)});
		directed.push_back('{mk(OP_CC, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
			32'h8000_0000, 31'h7FFF_FFFF, 0, 0), pred});
		directed.push_back('{mk(OP_CC, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
			32'h8000_0000, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF), pred});
		directed.push_back('{mk(OP_CB, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000,
			32'h7FFF_FFFF, 0, 31'h7FFF_FFFF, 0), pred});
		directed.push_back('{mk(OP_CB, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
			32'h8000_0000, 0, 0, 31'h7FFF_FFFF), pred});
		directed.push_back('{mk(OP_BC, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
			32'h7FFF_FFFF, 31'h7FFF_FFFF, 0, 0), pred});
		directed.push_back('{mk(OP_BC, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000,
			32'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF), pred});
		directed.push_back('{mk(OP_CC, 32'h0000_0001, 0, 0, 0, 31'h7FFF_FFFF, 0, 0), pred});
		directed.push_back('{mk(OP_CC, 32'h0003_0000, 32'h0004_0000, 0, 0,
			31'h0005_0000, 0, 0), pred});
		directed.push_back('{mk(OP_BC, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0001,
			32'h0000_0001, 31'h0000_0001, 0, 0), pred});
	endtask

	task automatic send_request(in_item_t q, int idle_chance);
		int gap;
		if (!quiet_phase && $urandom_range(0, 99) < idle_chance) begin
			in_valid <= 1'b0;
			gap = $urandom_range(1, 13);
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		in_data <= q;
		point_queue.push_back(contact_point(q));
		@(posedge clk);
		while (in_stall) @(posedge clk);
		@(negedge clk);
	endtask

	// stimulus
	initial begin
		in_item_t q;
		table_row_t row;
		int idle_chance;
		build_table();
		repeat (4) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		foreach (directed[k]) begin
			row = directed[k];
			if (row.want.known && row.want.res !== contact_point(row.req)) begin
				n_mismatch++;
				$display("table row %0d disagrees with prediction", k);
			end
			send_request(row.req, 30);
		end
		for (int k = 0; k < N_RANDOM; k++) begin
			if (k >= N_RANDOM - 150) quiet_phase = 1'b1;
			idle_chance = ((k / 200) % 2 == 0) ? 25 : 0;
			q = rand_request();
			send_request(q, idle_chance);
		end
		in_valid <= 1'b0;
		send_done = 1'b1;
	end

	// receiver stall bursts
	initial begin
		int gap;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (!quiet_phase && $urandom_range(0, 99) < 12) begin
				out_stall <= 1'b1;
				gap = $urandom_range(1, 13);
				repeat (gap) @(negedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	// result checking
	always @(posedge clk) begin
		out_item_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (point_queue.size() == 0) begin
				n_mismatch++;
				if (n_mismatch <= 10) $display("unexpected result %h", out_data);
			end else begin
				want = point_queue.pop_front();
				n_results++;
				if (want.degenerate) n_degen++;
				if (out_data.point_x !== want.point_x || out_data.point_y !== want.point_y
						|| out_data.degenerate !== want.degenerate) begin
					n_mismatch++;
					if (n_mismatch <= 10)
						$display("mismatch: expected x=%h y=%h dg=%b, got x=%h y=%h dg=%b",
							want.point_x, want.point_y, want.degenerate,
							out_data.point_x, out_data.point_y, out_data.degenerate);
				end
			end
		end
	end

	// end of run and timeout
	initial begin
		bit timed_out;
		timed_out = 1'b0;
		while (!(send_done && point_queue.size() == 0) && cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		if (cycles >= CYCLE_LIMIT) timed_out = 1'b1;
		if (!timed_out) repeat (TAIL_CYCLES) @(posedge clk);
		$display("%0d contact points checked over %0d cycles, %0d with zero-length normal",
			n_results, cycles, n_degen);
		$display("%0d mismatches", n_mismatch);
		if (!timed_out && n_mismatch == 0 && point_queue.size() == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule

FILE: sim.f
rtl/cpcb_pkg.sv
rtl/cpcb_front.sv
rtl/cpcb_fifo.sv
rtl/cpcb_div.sv
rtl/cpcb_back.sv
rtl/contact_point_circle_box.sv
bench/contact_point_circle_box_tb.sv
